### src/geq_pkg.sv
package geq_pkg;

  // Block dimensions.
  localparam int NUM_BANDS    = 29;
  localparam int MAX_SECTIONS = 20;
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC         = 28;

  // Derived widths.
  localparam int MEM_DEPTH = NUM_BANDS * MAX_SECTIONS;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int BIW       = $clog2(NUM_BANDS);
  localparam int BCW       = $clog2(NUM_BANDS + 1);
  localparam int SCW       = $clog2(MAX_SECTIONS + 1);
  localparam int SIG_W     = 40;
  localparam int HIST_W    = 4 * SIG_W;
  localparam int IN_SHIFT  = FRAC + 1 - SAMPLE_BITS;

  // Configuration register indexes.
  localparam logic REG_MASTER_GAIN = 1'b0;
  localparam logic REG_BAND_ENABLE = 1'b1;

  // Function codes of an input word.
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_COEF   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Coefficient selects.
  localparam logic [2:0] SEL_K    = 3'd0;
  localparam logic [2:0] SEL_V    = 3'd1;
  localparam logic [2:0] SEL_A    = 3'd2;
  localparam logic [2:0] SEL_NSEC = 3'd3;
  localparam logic [2:0] SEL_CM   = 3'd4;
  localparam logic [2:0] SEL_A0M  = 3'd5;

  typedef logic signed [SIG_W-1:0] sig_t;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BAND,
    ST_READ,
    ST_CALC,
    ST_GAIN
  } state_e;

  // Datapath steps of one fourth-order section, then the output scaling.
  typedef enum logic [3:0] {
    DP_T1,
    DP_P1,
    DP_T2,
    DP_P2U,
    DP_CX,
    DP_INNER,
    DP_V1,
    DP_D,
    DP_E,
    DP_CT,
    DP_TERM1,
    DP_KU,
    DP_W2,
    DP_Y,
    DP_GAIN
  } step_e;

  typedef struct packed {
    logic  load;
    logic  run;
    step_e step;
  } dp_ctrl_t;

  // Saturate a wide intermediate to the 40-bit signal format.
  function automatic sig_t sat40(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sh7F_FFFF_FFFF;
    lo = -hi - 48'sd1;
    if (v > hi) begin
      return sig_t'(hi);
    end else if (v < lo) begin
      return sig_t'(lo);
    end
    return sig_t'(v);
  endfunction

endpackage

### src/graphic_eq_section_cascade_top.sv
// Mono graphic equalizer: each sample word runs through the enabled bands in
// order, each band a cascade of up to 20 fourth-order sections whose history
// and section coefficients sit in single-port-per-direction RAMs. A section is
// a RAM read, then 14 steps through one shared 34 x 40 bit coefficient
// multiplier; a band that is disabled or has no sections is skipped, and the
// output scaling follows the last band. After reset and after each clear word
// the history RAM is zeroed one entry a cycle while input is stalled.
module graphic_eq_section_cascade_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [23:0] sample_i,
  input  logic [4:0]         band_i,
  input  logic [4:0]         section_i,
  input  logic [2:0]         coef_sel_i,
  input  logic signed [31:0] coef_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] sample_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import geq_pkg::*;

  state_e state_q, state_d;
  logic [BCW-1:0] band_q, band_d;
  logic [SCW-1:0] sect_q, sect_d;
  step_e          step_q, step_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [23:0]    gain_q;
  logic [28:0]    enable_q;
  logic [SCW-1:0] nsec_q [NUM_BANDS];
  logic signed [31:0] k_q [NUM_BANDS];
  logic signed [31:0] v_q [NUM_BANDS];
  logic signed [31:0] a_q [NUM_BANDS];
  logic           out_valid_q;
  logic signed [23:0] out_q;

  logic           accept;
  logic           out_free;
  logic           cfg_wr;
  logic           coef_ok;
  logic           sect_ok;
  logic [BIW-1:0] bidx;
  logic [BIW-1:0] wbidx;
  logic [SCW-1:0] nsec_w;
  logic [AW-1:0]  addr;
  logic [AW-1:0]  coef_addr;
  logic           hist_we;
  logic [AW-1:0]  hist_waddr;
  logic [HIST_W-1:0] hist_wdata;
  logic           rd_en;
  logic           load_out;
  dp_ctrl_t       dp_ctrl;
  logic [HIST_W-1:0] hist_rd;
  logic [HIST_W-1:0] hist_wb;
  logic [63:0]    coef_rd;
  logic signed [23:0] result;
  logic              hist_we_d;
  logic [AW-1:0]     hist_waddr_d;
  logic [HIST_W-1:0] hist_wdata_d;
  logic              wb_pend_q;
  logic [AW-1:0]     wb_addr_q;

  assign bidx      = band_q[BIW-1:0];
  assign wbidx     = band_i[BIW-1:0];
  assign addr      = AW'(bidx) * AW'(MAX_SECTIONS) + AW'(sect_q);
  assign coef_addr = AW'(wbidx) * AW'(MAX_SECTIONS) + AW'(section_i);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign coef_ok    = accept && (func_i == FUNC_COEF) && (6'(band_i) < 6'(NUM_BANDS));
  assign sect_ok    = coef_ok && (6'(section_i) < 6'(MAX_SECTIONS));

  // Section count clamped to the supported range.
  always_comb begin
    if (coef_value_i < 32'sd0) begin
      nsec_w = '0;
    end else if (coef_value_i > 32'(MAX_SECTIONS)) begin
      nsec_w = SCW'(MAX_SECTIONS);
    end else begin
      nsec_w = coef_value_i[SCW-1:0];
    end
  end

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[2])
      REG_MASTER_GAIN: prdata = {8'b0, gain_q};
      REG_BAND_ENABLE: prdata = {3'b0, enable_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 24'd262144;
      enable_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MASTER_GAIN: gain_q <= pwdata[23:0];
        REG_BAND_ENABLE: enable_q <= pwdata[28:0];
        default:         gain_q <= gain_q;
      endcase
    end
  end

  // Band coefficients; the section counts reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        nsec_q[i] <= '0;
      end
    end else if (coef_ok && coef_sel_i == SEL_NSEC) begin
      nsec_q[wbidx] <= nsec_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_ok) begin
      case (coef_sel_i)
        SEL_K:   k_q[wbidx] <= coef_value_i;
        SEL_V:   v_q[wbidx] <= coef_value_i;
        SEL_A:   a_q[wbidx] <= coef_value_i;
        default: ;
      endcase
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      band_q  <= '0;
      sect_q  <= '0;
      step_q  <= DP_T1;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      band_q  <= band_d;
      sect_q  <= sect_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
    end
  end

  // Next state: bands in order, sections in order, steps in order.
  always_comb begin
    state_d  = state_q;
    band_d   = band_q;
    sect_d   = sect_q;
    step_d   = step_q;
    clr_d    = clr_q;
    rd_en    = 1'b0;
    hist_we  = 1'b0;
    load_out = 1'b0;
    dp_ctrl  = '{load: 1'b0, run: 1'b0, step: step_q};
    unique case (state_q)
      ST_CLEAR: begin
        hist_we = 1'b1;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(MEM_DEPTH - 1)) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_SAMPLE) begin
            dp_ctrl.load = 1'b1;
            band_d       = '0;
            state_d      = ST_BAND;
          end else if (func_i == FUNC_CLEAR) begin
            clr_d   = '0;
            state_d = ST_CLEAR;
          end
        end
      end
      ST_BAND: begin
        if (band_q == BCW'(NUM_BANDS)) begin
          state_d = ST_GAIN;
        end else if (enable_q[bidx] && nsec_q[bidx] != '0) begin
          sect_d  = '0;
          state_d = ST_READ;
        end else begin
          band_d = band_q + BCW'(1);
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        step_d  = DP_T1;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        dp_ctrl.run = 1'b1;
        if (step_q == DP_Y) begin
          hist_we = 1'b1;
          sect_d  = sect_q + SCW'(1);
          if (sect_q + SCW'(1) == nsec_q[bidx]) begin
            band_d  = band_q + BCW'(1);
            state_d = ST_BAND;
          end else begin
            state_d = ST_READ;
          end
        end else begin
          step_d = step_e'(step_q + 4'd1);
        end
      end
      ST_GAIN: begin
        dp_ctrl.step = DP_GAIN;
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // History write port: the zeroing pass, or a section's write-back.
  assign hist_waddr = (state_q == ST_CLEAR) ? clr_q : addr;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      hist_wdata = '0;
    end else begin
      hist_wdata = hist_wb;
    end
  end

  geq_mem u_mem (
    .clk_i        (clk_i),
    .hist_we_i    (hist_we_d),
    .hist_waddr_i (hist_waddr_d),
    .hist_wdata_i (hist_wdata_d),
    .rd_en_i      (rd_en),
    .raddr_i      (addr),
    .hist_rdata_o (hist_rd),
    .cm_we_i      (sect_ok && coef_sel_i == SEL_CM),
    .a0m_we_i     (sect_ok && coef_sel_i == SEL_A0M),
    .coef_waddr_i (coef_addr),
    .coef_wdata_i (coef_value_i),
    .coef_rdata_o (coef_rd)
  );

  // A section's write-back is issued in the cycle after its last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_pend_q <= 1'b0;
    end else begin
      wb_pend_q <= hist_we && (state_q == ST_CALC);
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q <= addr;
  end

  always_comb begin
    if (wb_pend_q) begin
      hist_we_d    = 1'b1;
      hist_waddr_d = wb_addr_q;
      hist_wdata_d = hist_wb;
    end else begin
      hist_we_d    = hist_we && (state_q == ST_CLEAR);
      hist_waddr_d = hist_waddr;
      hist_wdata_d = hist_wdata;
    end
  end

  geq_dp u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (dp_ctrl),
    .sample_i (sample_i),
    .hist_i   (hist_rd),
    .coef_i   (coef_rd),
    .k_i      (k_q[bidx]),
    .v_i      (v_q[bidx]),
    .a_i      (a_q[bidx]),
    .gain_i   (gain_q),
    .hist_o   (hist_wb),
    .result_o (result)
  );

  // Output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

### src/geq_mul.sv
module geq_mul (
  input  logic signed [33:0] coef_i,
  input  logic signed [39:0] sig_i,
  output logic signed [58:0] prod_o
);

  // The signal is split so each partial product stays within 34 x 24 bits.
  logic signed [23:0] sig_hi;
  logic signed [16:0] sig_lo;
  logic signed [57:0] part_hi;
  logic signed [50:0] part_lo;

  assign sig_hi  = sig_i[39:16];
  assign sig_lo  = $signed({1'b0, sig_i[15:0]});
  assign part_hi = coef_i * sig_hi;
  assign part_lo = coef_i * sig_lo;

  // Product floored by 16 bits.
  assign prod_o = 59'(part_hi) + 59'(part_lo >>> 16);

endmodule

### src/geq_mem.sv
module geq_mem (
  input  logic                          clk_i,
  input  logic                          hist_we_i,
  input  logic [geq_pkg::AW-1:0]        hist_waddr_i,
  input  logic [geq_pkg::HIST_W-1:0]    hist_wdata_i,
  input  logic                          rd_en_i,
  input  logic [geq_pkg::AW-1:0]        raddr_i,
  output logic [geq_pkg::HIST_W-1:0]    hist_rdata_o,
  input  logic                          cm_we_i,
  input  logic                          a0m_we_i,
  input  logic [geq_pkg::AW-1:0]        coef_waddr_i,
  input  logic [31:0]                   coef_wdata_i,
  output logic [63:0]                   coef_rdata_o
);
  import geq_pkg::*;

  logic [HIST_W-1:0] hist_mem [MEM_DEPTH];
  logic [63:0]       coef_mem [MEM_DEPTH];
  logic [HIST_W-1:0] hist_rdata_q;
  logic [63:0]       coef_rdata_q;

  // Filter history: one word per section, read in the cycle before the section's first step.
  always_ff @(posedge clk_i) begin
    if (hist_we_i) begin
      hist_mem[hist_waddr_i] <= hist_wdata_i;
    end
    if (rd_en_i) begin
      hist_rdata_q <= hist_mem[raddr_i];
    end
  end

  // Section coefficients: cm in the upper half, a0m in the lower half.
  always_ff @(posedge clk_i) begin
    if (cm_we_i) begin
      coef_mem[coef_waddr_i][63:32] <= coef_wdata_i;
    end
    if (a0m_we_i) begin
      coef_mem[coef_waddr_i][31:0] <= coef_wdata_i;
    end
    if (rd_en_i) begin
      coef_rdata_q <= coef_mem[raddr_i];
    end
  end

  assign hist_rdata_o = hist_rdata_q;
  assign coef_rdata_o = coef_rdata_q;

endmodule

### src/geq_dp.sv
module geq_dp (
  input  logic                          clk_i,
  input  geq_pkg::dp_ctrl_t             ctrl_i,
  input  logic signed [23:0]            sample_i,
  input  logic [geq_pkg::HIST_W-1:0]    hist_i,
  input  logic [63:0]                   coef_i,
  input  logic signed [31:0]            k_i,
  input  logic signed [31:0]            v_i,
  input  logic signed [31:0]            a_i,
  input  logic [23:0]                   gain_i,
  output logic [geq_pkg::HIST_W-1:0]    hist_o,
  output logic signed [23:0]            result_o
);
  import geq_pkg::*;

  sig_t h1a, h1b, h2a, h2b;
  logic signed [31:0] cm_c, g_c;
  sig_t x_q, t1_q, p1_q, t2_q, p2_q, u_q, v1_q, e_q, term1_q;
  logic signed [41:0] tmp_q;
  logic signed [33:0] mc;
  sig_t               ms;
  logic signed [58:0] prod;
  sig_t               pm;
  sig_t               p2_n;
  sig_t               zg;
  logic signed [34:0] zs;
  logic signed [33:0] w2;

  assign {h1a, h1b, h2a, h2b} = hist_i;
  assign cm_c = coef_i[63:32];
  assign g_c  = coef_i[31:0];
  assign w2   = 34'sd536870912 + 34'(v_i);

  // Operand selection for the shared multiplier.
  always_comb begin
    mc = 34'(a_i);
    ms = h1b;
    unique case (ctrl_i.step)
      DP_T1:    begin mc = 34'(a_i);  ms = h1b; end
      DP_P1:    begin mc = 34'(a_i);  ms = t1_q; end
      DP_T2:    begin mc = 34'(a_i);  ms = h2b; end
      DP_P2U:   begin mc = 34'(a_i);  ms = t2_q; end
      DP_CX:    begin mc = 34'(cm_c); ms = p2_q; end
      DP_INNER: begin mc = 34'(k_i);  ms = u_q; end
      DP_V1:    begin mc = 34'(k_i);  ms = sig_t'(tmp_q); end
      DP_D:     begin mc = 34'(k_i);  ms = x_q; end
      DP_E:     begin mc = 34'(g_c);  ms = sig_t'(tmp_q); end
      DP_CT:    begin mc = 34'(cm_c); ms = sat40(48'(p2_q) - 48'(e_q)); end
      DP_TERM1: begin mc = 34'(v_i);  ms = sig_t'(tmp_q); end
      DP_KU:    begin mc = 34'(k_i);  ms = sat40(48'(e_q) + 48'(u_q)); end
      DP_W2:    begin mc = w2;        ms = sig_t'(tmp_q); end
      DP_Y:     begin mc = 34'(v_i);  ms = sig_t'(tmp_q); end
      DP_GAIN:  begin mc = $signed({10'b0, gain_i}); ms = x_q; end
      default:  begin mc = 34'(a_i);  ms = h1b; end
    endcase
  end

  geq_mul u_mul (
    .coef_i (mc),
    .sig_i  (ms),
    .prod_o (prod)
  );

  // Coefficient product with 28 fraction bits removed, saturated.
  assign pm   = sat40(48'(prod >>> 12));
  assign p2_n = sat40(48'(pm) - 48'(h2b));

  // Output scaling: 18 fraction bits off, then down to the sample format.
  assign zg = sat40(48'(prod >>> 2));
  assign zs = 35'(zg >>> IN_SHIFT);
  always_comb begin
    if (zs > 35'sd8388607) begin
      result_o = 24'sd8388607;
    end else if (zs < -35'sd8388608) begin
      result_o = -24'sd8388608;
    end else begin
      result_o = 24'(zs);
    end
  end

  // Step registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= sig_t'(sample_i) <<< IN_SHIFT;
    end else if (ctrl_i.run) begin
      unique case (ctrl_i.step)
        DP_T1:    t1_q <= sat40(48'(h1a) + 48'(pm));
        DP_P1:    p1_q <= sat40(48'(pm) - 48'(h1b));
        DP_T2:    t2_q <= sat40(48'(h2a) + 48'(pm));
        DP_P2U: begin
          p2_q <= p2_n;
          u_q  <= sat40((48'(p1_q) <<< 1) + 48'(p2_n));
        end
        DP_CX:    tmp_q <= -(42'(pm) <<< 1);
        DP_INNER: tmp_q <= 42'(sat40(48'(tmp_q) + 48'(pm)));
        DP_V1: begin
          v1_q <= sat40(48'(sat40(48'(p2_q) - (48'(p1_q) <<< 1))) + 48'(pm));
        end
        DP_D:     tmp_q <= 42'(sat40(48'(pm) - 48'(v1_q)));
        DP_E:     e_q <= pm;
        DP_CT:    tmp_q <= 42'(pm);
        DP_TERM1: term1_q <= sat40(-(48'(pm) <<< 1));
        DP_KU:    tmp_q <= 42'(pm);
        DP_W2:    tmp_q <= 42'(pm);
        DP_Y:     x_q <= sat40(48'(sat40(48'(x_q) + 48'(term1_q))) + 48'(pm));
        DP_GAIN:  x_q <= x_q;
        default:  x_q <= x_q;
      endcase
    end
  end

  // Write-back word: one_a = e, one_b = t1, two_a = p1, two_b = t2.
  assign hist_o = {e_q, t1_q, p1_q, t2_q};

endmodule

### verif/graphic_eq_section_cascade_top_test.sv
`timescale 1ns / 100ps

module graphic_eq_section_cascade_top_test;
  import geq_pkg::*;

  localparam int CYCLE_LIMIT = 25_000_000;
  // A clear word keeps the history RAM busy for one entry a cycle.
  localparam int SETTLE_CYCLES = 700;
  localparam int WORDS_PER_PHASE = 64;
  localparam longint MAX40 = (64'sd1 <<< 39) - 1;
  localparam longint MIN40 = -(64'sd1 <<< 39);
  localparam logic [2:0] ADDR_MASTER_GAIN = {REG_MASTER_GAIN, 2'b00};
  localparam logic [2:0] ADDR_BAND_ENABLE = {REG_BAND_ENABLE, 2'b00};
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = FUNC_SAMPLE;
  logic signed [23:0] sample = '0;
  logic [4:0]         band = '0;
  logic [4:0]         section = '0;
  logic [2:0]         coef_sel = SEL_K;
  logic signed [31:0] coef_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] sample_out;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  graphic_eq_section_cascade_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .sample_i     (sample),
    .band_i       (band),
    .section_i    (section),
    .coef_sel_i   (coef_sel),
    .coef_value_i (coef_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_o (sample_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Mirror of the equalizer state.
  longint unsigned gain_q;
  logic [28:0]     enable_q;
  longint          k_q [NUM_BANDS];
  longint          v_q [NUM_BANDS];
  longint          a_q [NUM_BANDS];
  int              nsec_q [NUM_BANDS];
  longint          cm_q [NUM_BANDS][MAX_SECTIONS];
  longint          a0m_q [NUM_BANDS][MAX_SECTIONS];
  longint          h1a_q [NUM_BANDS][MAX_SECTIONS];
  longint          h1b_q [NUM_BANDS][MAX_SECTIONS];
  longint          h2a_q [NUM_BANDS][MAX_SECTIONS];
  longint          h2b_q [NUM_BANDS][MAX_SECTIONS];
  bit              kvaw_q [NUM_BANDS][3];
  bit              cmw_q [NUM_BANDS][MAX_SECTIONS];
  bit              a0mw_q [NUM_BANDS][MAX_SECTIONS];

  logic signed [23:0] expected_out_q[$];
  int errors = 0;
  int n_words = 0;
  int n_samples = 0;
  int n_coef_words = 0;
  int n_clears = 0;
  int n_outputs = 0;
  int burst_left = 0;

  function automatic longint clip40(longint x);
    return x > MAX40 ? MAX40 : (x < MIN40 ? MIN40 : x);
  endfunction

  // Floor of c * x / 2^s, split so the partial products stay within 64 bits.
  function automatic longint mul_floor(longint c, longint x, int s);
    longint xh;
    longint xl;
    xh = x >>> 16;
    xl = x - xh * 65536;
    return (c * xh + ((c * xl) >>> 16)) >>> (s - 16);
  endfunction

  function automatic longint cmul(longint c, longint x);
    return clip40(mul_floor(c, x, FRAC));
  endfunction

  // One band: the cascade of fourth-order sections, updating history.
  function automatic longint eq_band(int b, longint x);
    longint w2, c, g, t1, p1, t2, p2, u, inner, v1, e, term1, term2, y;
    w2 = (64'sd1 <<< (FRAC + 1)) + v_q[b];
    for (int s = 0; s < nsec_q[b]; s++) begin
      c = cm_q[b][s];
      g = a0m_q[b][s];
      t1 = clip40(h1a_q[b][s] + cmul(a_q[b], h1b_q[b][s]));
      p1 = clip40(cmul(a_q[b], t1) - h1b_q[b][s]);
      t2 = clip40(h2a_q[b][s] + cmul(a_q[b], h2b_q[b][s]));
      p2 = clip40(cmul(a_q[b], t2) - h2b_q[b][s]);
      u = clip40(2 * p1 + p2);
      inner = clip40(-2 * cmul(c, p2) + cmul(k_q[b], u));
      v1 = clip40(clip40(p2 - 2 * p1) + cmul(k_q[b], inner));
      e = cmul(g, clip40(cmul(k_q[b], x) - v1));
      term1 = clip40(-2 * cmul(v_q[b], cmul(c, clip40(p2 - e))));
      term2 = cmul(v_q[b], cmul(w2, cmul(k_q[b], clip40(e + u))));
      y = clip40(clip40(x + term1) + term2);
      h1b_q[b][s] = t1;
      h1a_q[b][s] = e;
      h2b_q[b][s] = t2;
      h2a_q[b][s] = p1;
      x = y;
    end
    return x;
  endfunction

  function automatic logic signed [23:0] eq_process(logic signed [23:0] smp);
    longint x;
    longint z;
    x = longint'(smp) * (64'sd1 <<< IN_SHIFT);
    for (int b = 0; b < NUM_BANDS; b++) begin
      if (enable_q[b]) begin
        x = eq_band(b, x);
      end
    end
    z = clip40(mul_floor(longint'(gain_q), x, 18)) >>> IN_SHIFT;
    if (z > 64'sd8388607) begin
      z = 64'sd8388607;
    end else if (z < -64'sd8388608) begin
      z = -64'sd8388608;
    end
    return z[23:0];
  endfunction

  function automatic void eq_store_coef(int b, int s, logic [2:0] sel, longint val);
    if (b >= NUM_BANDS) begin
      return;
    end
    case (sel)
      SEL_K: begin
        k_q[b] = val;
        kvaw_q[b][0] = 1'b1;
      end
      SEL_V: begin
        v_q[b] = val;
        kvaw_q[b][1] = 1'b1;
      end
      SEL_A: begin
        a_q[b] = val;
        kvaw_q[b][2] = 1'b1;
      end
      SEL_NSEC: begin
        nsec_q[b] = val < 0 ? 0 : (val > MAX_SECTIONS ? MAX_SECTIONS : int'(val));
      end
      SEL_CM: begin
        if (s < MAX_SECTIONS) begin
          cm_q[b][s] = val;
          cmw_q[b][s] = 1'b1;
        end
      end
      SEL_A0M: begin
        if (s < MAX_SECTIONS) begin
          a0m_q[b][s] = val;
          a0mw_q[b][s] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void eq_clear_history();
    foreach (h1a_q[b, s]) begin
      h1a_q[b][s] = 0;
      h1b_q[b][s] = 0;
      h2a_q[b][s] = 0;
      h2b_q[b][s] = 0;
    end
  endfunction

  // A band may be enabled once every coefficient its sections read is loaded.
  function automatic bit band_loaded(int b);
    if (nsec_q[b] == 0) begin
      return 1'b1;
    end
    if (!(kvaw_q[b][0] && kvaw_q[b][1] && kvaw_q[b][2])) begin
      return 1'b0;
    end
    for (int s = 0; s < nsec_q[b]; s++) begin
      if (!(cmw_q[b][s] && a0mw_q[b][s])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [28:0] loaded_mask();
    logic [28:0] m;
    for (int b = 0; b < NUM_BANDS; b++) begin
      m[b] = band_loaded(b);
    end
    return m;
  endfunction

  function automatic logic signed [31:0] rand_coef();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
  endfunction

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Run guard.
  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) begin
      @(posedge clk);
    end
    $display("Timeout after %0d cycles at %0t", CYCLE_LIMIT, $time);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver stall pattern: stretches of no, light or heavy back-pressure.
  int stall_run = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, 60);
      stall_mode = $urandom_range(0, 3);
    end
    stall_run--;
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      3: out_stall <= 1'b1;
      default: out_stall <= 1'b0;
    endcase
  end

  // Output checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_outputs++;
      if (expected_out_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, actual %0d", $time, sample_out);
      end else begin
        if (sample_out !== expected_out_q[0]) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, expected_out_q[0], sample_out);
        end
        void'(expected_out_q.pop_front());
      end
    end
  end

  // Drive one input word in a burst pattern, then update the mirror on acceptance.
  task automatic send_word(logic [1:0] f, logic signed [23:0] smp, logic [4:0] b,
                           logic [4:0] s, logic [2:0] sel, logic signed [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    func <= f;
    sample <= smp;
    band <= b;
    section <= s;
    coef_sel <= sel;
    coef_value <= val;
    forever begin
      @(posedge clk);
      if (!in_stall) begin
        break;
      end
    end
    n_words++;
    case (f)
      FUNC_SAMPLE: begin
        n_samples++;
        expected_out_q.push_back(eq_process(smp));
      end
      FUNC_COEF: begin
        n_coef_words++;
        eq_store_coef(int'(b), int'(s), sel, longint'(val));
      end
      FUNC_CLEAR: begin
        n_clears++;
        eq_clear_history();
      end
      default: begin
      end
    endcase
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) begin
        break;
      end
    end
    if (addr == ADDR_MASTER_GAIN) begin
      gain_q = data[23:0];
    end else begin
      enable_q = data[28:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until every expected output has arrived and the block has settled.
  task automatic wait_idle();
    drop_valid();
    while (expected_out_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a section count, first loading any coefficient its sections will read.
  task automatic set_sections(int b, logic signed [31:0] raw);
    int n;
    n = raw < 0 ? 0 : (raw > MAX_SECTIONS ? MAX_SECTIONS : int'(raw));
    if (n > 0) begin
      for (int i = 0; i < 3; i++) begin
        if (!kvaw_q[b][i]) begin
          send_word(FUNC_COEF, '0, 5'(b), '0, SEL_K + 3'(i), rand_coef());
        end
      end
    end
    for (int s = 0; s < n; s++) begin
      if (!cmw_q[b][s]) begin
        send_word(FUNC_COEF, '0, 5'(b), 5'(s), SEL_CM, rand_coef());
      end
      if (!a0mw_q[b][s]) begin
        send_word(FUNC_COEF, '0, 5'(b), 5'(s), SEL_A0M, rand_coef());
      end
    end
    send_word(FUNC_COEF, '0, 5'(b), '0, SEL_NSEC, raw);
  endtask

  task automatic random_word();
    int pick;
    logic signed [31:0] raw;
    logic signed [23:0] smp;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) begin
      smp = 24'($signed($urandom_range(0, 2047)) - 1024);
    end else begin
      smp = 24'($urandom);
    end
    if (pick < 60) begin
      send_word(FUNC_SAMPLE, smp, 5'($urandom), 5'($urandom), 3'($urandom), $urandom);
    end else if (pick < 82) begin
      send_word(FUNC_COEF, smp, 5'($urandom_range(0, NUM_BANDS - 1)),
                5'($urandom_range(0, MAX_SECTIONS - 1)),
                ($urandom_range(0, 1) == 0) ? SEL_CM + 3'($urandom_range(0, 1))
                                            : SEL_K + 3'($urandom_range(0, 2)),
                rand_coef());
    end else if (pick < 90) begin
      case ($urandom_range(0, 9))
        0: raw = $urandom;
        1: raw = MAX_SECTIONS;
        2: raw = -$signed(32'($urandom_range(1, 9)));
        default: raw = $urandom_range(0, 3);
      endcase
      set_sections($urandom_range(0, NUM_BANDS - 1), raw);
    end else if (pick < 94) begin
      send_word(FUNC_CLEAR, smp, 5'($urandom), 5'($urandom), 3'($urandom), $urandom);
    end else begin
      // Words the block ignores: unknown function, address out of range.
      case ($urandom_range(0, 2))
        0: send_word(FUNC_NONE, smp, 5'($urandom), 5'($urandom), 3'($urandom), $urandom);
        1: send_word(FUNC_COEF, smp, 5'($urandom_range(NUM_BANDS, 31)), 5'($urandom),
                     3'($urandom), $urandom);
        default: send_word(FUNC_COEF, smp, 5'($urandom_range(0, NUM_BANDS - 1)),
                           5'($urandom_range(MAX_SECTIONS, 31)),
                           ($urandom_range(0, 1) == 0) ? SEL_CM : SEL_A0M, $urandom);
      endcase
    end
  endtask

  typedef struct {
    logic [1:0]         f;
    logic signed [23:0] smp;
    logic [4:0]         b;
    logic [4:0]         s;
    logic [2:0]         sel;
    logic signed [31:0] val;
    bit                 typed;
    logic signed [23:0] want;
  } stim_row_t;

  // Directed words: unity gain passthrough, ignored words and count clamping, a clear
  // word and one more passthrough sample, then band 0 loaded with one section.
  stim_row_t directed_rows[] = '{
    '{FUNC_SAMPLE, 24'sh7FFFFF, 0, 0, SEL_K, 0, 1, 24'sh7FFFFF},
    '{FUNC_SAMPLE, 24'sh800000, 0, 0, SEL_K, 0, 1, 24'sh800000},
    '{FUNC_SAMPLE, 0, 0, 0, SEL_K, 0, 1, 0},
    '{FUNC_SAMPLE, -1, 0, 0, SEL_K, 0, 1, -1},
    '{FUNC_SAMPLE, 1, 0, 0, SEL_K, 0, 1, 1},
    '{FUNC_NONE, 24'sh123456, 0, 0, SEL_K, 0, 0, 0},
    '{FUNC_COEF, 0, 31, 0, SEL_K, 32'sh7FFFFFFF, 0, 0},
    '{FUNC_COEF, 0, 0, 25, SEL_CM, 32'sh10000000, 0, 0},
    '{FUNC_COEF, 0, 0, 0, 3'd6, -1, 0, 0},
    '{FUNC_COEF, 0, 0, 0, 3'd7, 32'sh80000000, 0, 0},
    '{FUNC_COEF, 0, 1, 0, SEL_NSEC, -5, 0, 0},
    '{FUNC_COEF, 0, 2, 0, SEL_NSEC, 100, 0, 0},
    '{FUNC_CLEAR, 0, 0, 0, SEL_K, 0, 0, 0},
    '{FUNC_SAMPLE, 24'sd12345, 0, 0, SEL_K, 0, 1, 24'sd12345},
    '{FUNC_COEF, 0, 0, 0, SEL_K, 32'sh04000000, 0, 0},
    '{FUNC_COEF, 0, 0, 0, SEL_V, 32'sh08000000, 0, 0},
    '{FUNC_COEF, 0, 0, 0, SEL_A, -32'sh02000000, 0, 0},
    '{FUNC_COEF, 0, 0, 0, SEL_CM, 32'sh03000000, 0, 0},
    '{FUNC_COEF, 0, 0, 0, SEL_A0M, 32'sh0C000000, 0, 0},
    '{FUNC_COEF, 0, 0, 0, SEL_NSEC, 1, 0, 0}
  };

  initial begin
    logic [31:0] gain_pick;
    gain_q = 262144;
    enable_q = '0;
    foreach (k_q[b]) begin
      k_q[b] = 0;
      v_q[b] = 0;
      a_q[b] = 0;
      nsec_q[b] = 0;
      kvaw_q[b] = '{0, 0, 0};
    end
    foreach (cm_q[b, s]) begin
      cm_q[b][s] = 0;
      a0m_q[b][s] = 0;
      cmw_q[b][s] = 0;
      a0mw_q[b][s] = 0;
    end
    eq_clear_history();

    @(posedge rst_n);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].f, directed_rows[i].smp, directed_rows[i].b,
                directed_rows[i].s, directed_rows[i].sel, directed_rows[i].val);
      if (directed_rows[i].typed && expected_out_q[$] !== directed_rows[i].want) begin
        errors++;
        $display("%0t: directed row %0d predicts %0d, table expects %0d", $time, i,
                 expected_out_q[$], directed_rows[i].want);
      end
    end

    // Random phases, each under its own gain and band selection.
    for (int phase = 0; phase < 9; phase++) begin
      wait_idle();
      case (phase)
        0: gain_pick = 0;
        1: gain_pick = 262144;
        8: gain_pick = 24'hFFFFFF;
        default: gain_pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                           : $urandom_range(131072, 524288);
      endcase
      if (phase == 8) begin
        for (int b = 0; b < NUM_BANDS; b++) begin
          set_sections(b, $urandom_range(0, 2));
        end
        wait_idle();
      end
      reg_write(ADDR_MASTER_GAIN, gain_pick);
      case (phase)
        1: reg_write(ADDR_BAND_ENABLE, 32'h0);
        2: reg_write(ADDR_BAND_ENABLE, 32'h3);
        8: reg_write(ADDR_BAND_ENABLE, 32'h1FFF_FFFF);
        default: reg_write(ADDR_BAND_ENABLE, 32'($urandom) & 32'(loaded_mask()));
      endcase
      while (n_words < (phase + 1) * WORDS_PER_PHASE) begin
        random_word();
      end
    end

    wait_idle();
    $display("Covered %0d sample words, %0d coefficient words and %0d clears; %0d outputs",
             n_samples, n_coef_words, n_clears, n_outputs);
    $display("checked over nine gain and band settings, unity gain through full scale.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
